// File: sv/adbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adbd_pkg;

    localparam int MemoryBytes   = 524288;
    localparam int SampleLimit   = MemoryBytes / 16 * 28;
    localparam bit LimitFits     = SampleLimit <= 32'h100000;
    localparam logic [19:0] LastIndex = 20'(SampleLimit - 1);

    localparam logic [3:0] PosHeader    = 4'd0;
    localparam logic [3:0] PosFlags     = 4'd1;
    localparam logic [3:0] PosFirstData = 4'd2;
    localparam logic [3:0] PosLastData  = 4'd15;

    localparam int FlagLoopEnd   = 0;
    localparam int FlagRepeat    = 1;
    localparam int FlagLoopStart = 2;

    localparam int FifoDepth = 2;
    localparam int FifoAw    = $clog2(FifoDepth);

    typedef struct packed {
        logic [7:0]  data;
        logic [3:0]  shift;
        logic [3:0]  filt;
        logic        clr;
        logic [19:0] index;
        logic        lstart;
        logic        lvalid;
        logic [19:0] loop_begin;
        logic [19:0] loop_length;
        logic        eos;
    } t_job;

    function automatic logic signed [7:0] coef_one(input logic [3:0] filt);
        logic signed [7:0] k;
        case (filt)
            4'd1: k = 8'sd60;
            4'd2: k = 8'sd115;
            4'd3: k = 8'sd98;
            4'd4: k = 8'sd122;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [7:0] coef_two(input logic [3:0] filt);
        logic signed [7:0] k;
        case (filt)
            4'd2: k = -8'sd52;
            4'd3: k = -8'sd55;
            4'd4: k = -8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: sv/adbd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface adbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface adbd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [19:0]        sample_index;
    logic               at_loop_start;
    logic               loop_valid;
    logic [19:0]        loop_begin;
    logic [19:0]        loop_length;
    logic               end_of_sound;
    logic               last;

    modport source (output valid, output sample, output sample_index, output at_loop_start,
                    output loop_valid, output loop_begin, output loop_length,
                    output end_of_sound, output last, input ready);
    modport sink (input valid, input sample, input sample_index, input at_loop_start,
                  input loop_valid, input loop_begin, input loop_length,
                  input end_of_sound, input last, output ready);
endinterface
`default_nettype wire

// File: sv/adbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module adbd_front
    import adbd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    adbd_in_if.sink     i_in,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_stop_at_end;
    logic        r_stopped, n_stopped;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_header, n_header;
    logic [2:0]  r_flags, n_flags;
    logic [19:0] r_cnt, n_cnt;
    logic [19:0] r_lsi, n_lsi;
    logic        r_clr, n_clr;

    logic        accept;
    logic        first;
    logic [19:0] cnt_c, lsi_c, lsi_d, idx1;
    logic [3:0]  pos_c;
    logic        stp_c, lstart, block_end, lvalid, eos;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        first     = i_in.first_byte;
        cnt_c     = first ? '0 : r_cnt;
        lsi_c     = first ? '0 : r_lsi;
        pos_c     = first ? PosHeader : r_pos;
        stp_c     = first ? 1'b0 : r_stopped;
        n_stopped = r_stopped;
        n_pos     = r_pos;
        n_header  = r_header;
        n_flags   = r_flags;
        n_cnt     = r_cnt;
        n_lsi     = r_lsi;
        n_clr     = r_clr;
        lstart    = (pos_c == PosFirstData) && r_flags[FlagLoopStart];
        lsi_d     = lstart ? cnt_c : lsi_c;
        idx1      = cnt_c + 20'd1;
        block_end = (pos_c == PosLastData);
        lvalid    = block_end && r_flags[FlagLoopEnd] && r_flags[FlagRepeat];
        eos       = i_in.last_byte
                    || (block_end && r_stop_at_end && r_flags[FlagLoopEnd])
                    || (LimitFits && idx1 == LastIndex);
        o_push    = 1'b0;
        o_job.data        = i_in.data_byte;
        o_job.shift       = r_header[3:0];
        o_job.filt        = r_header[7:4];
        o_job.clr         = first || r_clr;
        o_job.index       = cnt_c;
        o_job.lstart      = lstart;
        o_job.lvalid      = lvalid;
        o_job.loop_begin  = lvalid ? lsi_d : '0;
        o_job.loop_length = lvalid ? (idx1 + 20'd1 - lsi_d) : '0;
        o_job.eos         = eos;
        if (accept) begin
            n_cnt     = cnt_c;
            n_lsi     = lsi_c;
            n_pos     = pos_c;
            n_stopped = stp_c;
            n_clr     = first || r_clr;
            if (!stp_c) begin
                n_pos = pos_c + 4'd1;
                if (pos_c == PosHeader) begin
                    n_header  = i_in.data_byte;
                    n_stopped = i_in.last_byte;
                end else if (pos_c == PosFlags) begin
                    n_flags   = i_in.data_byte[2:0];
                    n_stopped = i_in.last_byte;
                end else begin
                    o_push    = 1'b1;
                    n_lsi     = lsi_d;
                    n_cnt     = cnt_c + 20'd2;
                    n_stopped = eos;
                    n_clr     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_at_end <= 1'b1;
            r_stopped     <= 1'b0;
            r_pos         <= '0;
            r_header      <= '0;
            r_flags       <= '0;
            r_cnt         <= '0;
            r_lsi         <= '0;
            r_clr         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stop_at_end <= i_cfg_wdata;
            end
            r_stopped <= n_stopped;
            r_pos     <= n_pos;
            r_header  <= n_header;
            r_flags   <= n_flags;
            r_cnt     <= n_cnt;
            r_lsi     <= n_lsi;
            r_clr     <= n_clr;
        end
    end

endmodule
`default_nettype wire

// File: sv/adbd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module adbd_fifo
    import adbd_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    input  wire   i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_job
);

    t_job              r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp, r_rp;
    logic [FifoAw:0]   r_cnt;

    assign o_full  = (r_cnt == (FifoAw+1)'(FifoDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FifoAw'(FifoDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FifoAw'(FifoDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/adbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module adbd_back
    import adbd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    adbd_out_if.source  o_out
);

    logic               r_phase;
    logic signed [15:0] r_p1, r_p2;
    logic               r_ov;
    logic signed [15:0] r_sample;
    logic [19:0]        r_index;
    logic               r_lstart, r_lvalid, r_eos, r_last;
    logic [19:0]        r_lbegin, r_llength;

    logic               advance;
    logic signed [15:0] p1, p2, base, smp;
    logic [3:0]         nib;
    logic signed [7:0]  k0, k1;
    logic signed [23:0] m1, m2;
    logic signed [24:0] acc;
    logic [24:0]        mag;
    logic [18:0]        q;
    logic signed [19:0] r;

    assign advance = !i_empty && (!r_ov || o_out.ready);
    assign o_pop   = advance && r_phase;

    // one filter step per cycle while the queue is not empty and the output can take it, low nibble first
    always_comb begin
        p1   = (i_job.clr && !r_phase) ? '0 : r_p1;
        p2   = (i_job.clr && !r_phase) ? '0 : r_p2;
        nib  = r_phase ? i_job.data[7:4] : i_job.data[3:0];
        base = $signed({nib, 12'b0}) >>> i_job.shift;
        k0   = coef_one(i_job.filt);
        k1   = coef_two(i_job.filt);
        m1   = 24'(p1) * 24'(k0);
        m2   = 24'(p2) * 24'(k1);
        acc  = $signed({{3{base[15]}}, base, 6'b0}) + 25'(m1) + 25'(m2);
        mag  = acc[24] ? 25'(-acc) : 25'(acc);
        q    = 19'((mag + 25'd32) >> 6);
        r    = acc[24] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (r > 20'sd32767) begin
            smp = 16'sh7FFF;
        end else if (r < -20'sd32768) begin
            smp = 16'sh8000;
        end else begin
            smp = r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sample  <= smp;
            r_index   <= r_phase ? i_job.index + 20'd1 : i_job.index;
            r_lstart  <= !r_phase && i_job.lstart;
            r_lvalid  <= r_phase && i_job.lvalid;
            r_lbegin  <= r_phase ? i_job.loop_begin : '0;
            r_llength <= r_phase ? i_job.loop_length : '0;
            r_eos     <= r_phase && i_job.eos;
            r_last    <= r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_p1    <= '0;
            r_p2    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (advance) begin
                r_phase <= !r_phase;
                r_p2    <= p1;
                r_p1    <= smp;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.sample        = r_sample;
    assign o_out.sample_index  = r_index;
    assign o_out.at_loop_start = r_lstart;
    assign o_out.loop_valid    = r_lvalid;
    assign o_out.loop_begin    = r_lbegin;
    assign o_out.loop_length   = r_llength;
    assign o_out.end_of_sound  = r_eos;
    assign o_out.last          = r_last;

endmodule
`default_nettype wire

// File: sv/adbd_block_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Block ADPCM decoder: takes one stream byte per item (16-byte blocks of header,
// flags and 14 data bytes) and returns two 16-bit PCM samples for every data
// byte, with sample index, loop points and end-of-sound marks. Header and flag
// bytes are absorbed by the front end; each data byte then passes the filter
// unit, which runs one multiply-accumulate step per sample. A two-entry queue
// sits between byte parsing and filtering, and the output is registered, so a
// new byte is taken while samples still wait at the output. first_byte starts a
// new sound; stop_at_end (reset 1) is written through i_cfg_we/i_cfg_wdata.
module adpcm_block_decoder_with_loops
    import adbd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    adbd_in_if.sink     i_in,
    adbd_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata
);

    logic push, pop, full, empty;
    t_job job_in, job_out;

    adbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    adbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    adbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import adbd_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 8;
    localparam int PendingMax   = 32;
    localparam int FilterCount  = 5;
    localparam int PcmMax       = 32767;
    localparam int PcmMin       = -32768;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [19:0]        index;
        logic               lstart;
        logic               lvalid;
        logic [19:0]        lbegin;
        logic [19:0]        llen;
        logic               eos;
        logic               hi;
    } t_pcm;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    adbd_in_if  byte_if ();
    adbd_out_if pcm_if ();

    adpcm_block_decoder_with_loops i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (byte_if),
        .o_out       (pcm_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder state as seen by the predictor
    int          hist1 = 0;
    int          hist2 = 0;
    logic [3:0]  blk_pos = '0;
    logic [7:0]  blk_hdr = '0;
    logic [2:0]  blk_flags = '0;
    logic [19:0] smp_count = '0;
    logic [19:0] loop_mark = '0;
    logic        halted = 1'b0;
    logic        stop_at_end_cfg = 1'b1;

    t_byte_item byte_q[$];
    t_pcm       pcm_q[$];
    t_byte_item cur_byte;

    int n_queued = 0;
    int n_taken = 0;
    int n_samples = 0;
    int n_loops = 0;
    int n_ends = 0;
    int n_fail = 0;
    int n_cycles = 0;
    int src_gap = 0;
    int snk_hold = 0;
    bit idling_on = 1'b1;
    bit long_hold_done = 1'b0;

    function automatic logic signed [15:0] filter_step(input logic [3:0] nib);
        int base, acc, r, k0, k1;
        base = $signed(nib);
        base = base * 4096;
        base = base >>> blk_hdr[3:0];
        k0 = 0;
        k1 = 0;
        case (blk_hdr[7:4])
            4'd1: k0 = 60;
            4'd2: begin
                k0 = 115;
                k1 = -52;
            end
            4'd3: begin
                k0 = 98;
                k1 = -55;
            end
            4'd4: begin
                k0 = 122;
                k1 = -60;
            end
            default: ;
        endcase
        acc = base * 64 + hist1 * k0 + hist2 * k1;
        r = (acc >= 0) ? (acc + 32) / 64 : -((32 - acc) / 64);
        if (r > PcmMax) r = PcmMax;
        if (r < PcmMin) r = PcmMin;
        hist2 = hist1;
        hist1 = r;
        return 16'(r);
    endfunction

    function automatic void decode_byte(input t_byte_item it);
        logic [3:0]  pos;
        logic [3:0]  nib;
        logic [19:0] idx;
        logic        blk_end;
        t_pcm        smp;
        if (it.first) begin
            hist1 = 0;
            hist2 = 0;
            blk_pos = PosHeader;
            smp_count = '0;
            loop_mark = '0;
            halted = 1'b0;
        end
        if (halted) return;
        pos = blk_pos;
        blk_pos = pos + 4'd1;
        if (pos == PosHeader || pos == PosFlags) begin
            if (pos == PosHeader) blk_hdr = it.data;
            else blk_flags = it.data[2:0];
            if (it.last) halted = 1'b1;
            return;
        end
        if (pos == PosFirstData && blk_flags[FlagLoopStart]) loop_mark = smp_count;
        for (int k = 0; k < 2; k++) begin
            nib = (k == 0) ? it.data[3:0] : it.data[7:4];
            idx = smp_count;
            blk_end = (k == 1) && (pos == PosLastData);
            smp.sample = filter_step(nib);
            smp.index = idx;
            smp.lstart = (k == 0) && (pos == PosFirstData) && blk_flags[FlagLoopStart];
            smp.lvalid = blk_end && blk_flags[FlagLoopEnd] && blk_flags[FlagRepeat];
            smp.lbegin = smp.lvalid ? loop_mark : '0;
            smp.llen = smp.lvalid ? 20'(idx + 20'd1 - loop_mark) : '0;
            smp.eos = (k == 1) && (it.last
                      || (blk_end && stop_at_end_cfg && blk_flags[FlagLoopEnd])
                      || (LimitFits && idx == LastIndex));
            smp.hi = (k == 1);
            pcm_q.push_back(smp);
            smp_count = idx + 20'd1;
            if (smp.eos) halted = 1'b1;
        end
        if (it.last) halted = 1'b1;
    endfunction

    function automatic string pcm_str(input t_pcm p);
        return $sformatf("sample=%0d index=%0d lstart=%b lvalid=%b lbegin=%0d %s",
                         p.sample, p.index, p.lstart, p.lvalid, p.lbegin,
                         $sformatf("llen=%0d eos=%b hi=%b", p.llen, p.eos, p.hi));
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(cur_byte);
                n_taken++;
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (src_gap == 0 && idling_on && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 9);
                if (src_gap > 0) begin
                    src_gap--;
                    byte_if.valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    cur_byte = byte_q.pop_front();
                    byte_if.valid <= 1'b1;
                    byte_if.data_byte <= cur_byte.data;
                    byte_if.first_byte <= cur_byte.first;
                    byte_if.last_byte <= cur_byte.last;
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor and ready control
    always @(posedge i_clk) begin
        t_pcm got, exp_smp;
        if (!i_rst_n) begin
            pcm_if.ready <= 1'b0;
            snk_hold = 0;
        end else begin
            if (pcm_if.valid && pcm_if.ready) begin
                got.sample = pcm_if.sample;
                got.index = pcm_if.sample_index;
                got.lstart = pcm_if.at_loop_start;
                got.lvalid = pcm_if.loop_valid;
                got.lbegin = pcm_if.loop_begin;
                got.llen = pcm_if.loop_length;
                got.eos = pcm_if.end_of_sound;
                got.hi = pcm_if.last;
                n_samples++;
                if (got.lvalid) n_loops++;
                if (got.eos) n_ends++;
                if (pcm_q.size() == 0) begin
                    $display("%0t: unexpected sample %s", $time, pcm_str(got));
                    n_fail++;
                end else begin
                    exp_smp = pcm_q.pop_front();
                    if (got !== exp_smp) begin
                        $display("%0t: mismatch expected %s", $time, pcm_str(exp_smp));
                        $display("%0t:          actual   %s", $time, pcm_str(got));
                        n_fail++;
                    end
                end
            end
            if (snk_hold > 0) begin
                snk_hold--;
                pcm_if.ready <= 1'b0;
            end else if (!long_hold_done && n_samples >= 100) begin
                // long back-pressure so the input side fills and stalls
                long_hold_done = 1'b1;
                snk_hold = 150;
                pcm_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                snk_hold = $urandom_range(1, 9) - 1;
                pcm_if.ready <= 1'b0;
            end else begin
                pcm_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("%0t: timeout, %0d samples still expected", $time, pcm_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] d, input logic f, input logic l);
        t_byte_item it;
        it.data = d;
        it.first = f;
        it.last = l;
        while (byte_q.size() >= PendingMax) @(posedge i_clk);
        byte_q.push_back(it);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || pcm_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_stop_at_end(input logic v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stop_at_end_cfg = v;
    endtask

    function automatic logic [7:0] random_header();
        logic [3:0] filt, shift;
        filt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(FilterCount, 15))
                                           : 4'($urandom_range(0, FilterCount - 1));
        shift = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(13, 15))
                                            : 4'($urandom_range(0, 12));
        return {filt, shift};
    endfunction

    task automatic queue_sound(input int n_blocks, input bit noisy);
        int         n_bytes, cut;
        logic [7:0] d;
        logic       f, l;
        n_bytes = n_blocks * 16;
        cut = (noisy && $urandom_range(0, 2) == 0) ? $urandom_range(1, n_bytes) : n_bytes;
        for (int i = 0; i < cut; i++) begin
            case (i % 16)
                0: d = random_header();
                1: begin
                    d = 8'($urandom_range(0, 255));
                    d[FlagLoopEnd] = (i / 16 == n_blocks - 1) ? 1'($urandom_range(0, 1))
                                                               : ($urandom_range(0, 7) == 0);
                end
                default: d = 8'($urandom_range(0, 255));
            endcase
            f = (i == 0) || (noisy && $urandom_range(0, 39) == 0);
            if (i == cut - 1) l = noisy || $urandom_range(0, 1);
            else l = noisy && $urandom_range(0, 39) == 0;
            queue_byte(d, f, l);
        end
    endtask

    task automatic random_sounds(input int n_items);
        int start;
        start = n_queued;
        while (n_queued - start < n_items) begin
            queue_sound($urandom_range(1, 4), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        byte_if.first_byte = 1'b0;
        byte_if.last_byte = 1'b0;
        pcm_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // loop start, repeat and loop end in one block, clamping data, stop at end
        queue_byte(8'h40, 1'b1, 1'b0);
        queue_byte(8'h07, 1'b0, 1'b0);
        queue_byte(8'h77, 1'b0, 1'b0);
        queue_byte(8'h77, 1'b0, 1'b0);
        queue_byte(8'h77, 1'b0, 1'b0);
        queue_byte(8'h88, 1'b0, 1'b0);
        queue_byte(8'h88, 1'b0, 1'b0);
        queue_byte(8'h88, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'h08, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0);
        queue_byte(8'hF7, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h10, 1'b0, 1'b0);
        // stopped: ignored
        queue_byte(8'h55, 1'b0, 1'b0);
        // unknown filter, shift beyond twelve, last byte on data
        queue_byte(8'hFD, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h8F, 1'b0, 1'b0);
        queue_byte(8'h78, 1'b0, 1'b1);
        // last byte on a header, then on a flag byte
        queue_byte(8'h3C, 1'b1, 1'b1);
        queue_byte(8'h1C, 1'b1, 1'b0);
        queue_byte(8'hF8, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b0);

        write_stop_at_end(1'b0);
        random_sounds(130);
        wait_drained();
        random_sounds(130);

        write_stop_at_end(1'b1);
        random_sounds(125);
        idling_on = 1'b0;
        random_sounds(125);

        write_stop_at_end(1'b0);
        random_sounds(120);

        write_stop_at_end(1'b1);
        random_sounds(130);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("tb_top: %0d bytes sent, %0d samples checked, stop_at_end 0 and 1",
                 n_taken, n_samples);
        $display("tb_top: %0d loop points and %0d end-of-sound marks seen",
                 n_loops, n_ends);
        if (n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/adbd_pkg.sv
sv/adbd_if.sv
sv/adbd_front.sv
sv/adbd_fifo.sv
sv/adbd_back.sv
sv/adbd_block_decoder_top.sv
dv/tb_top.sv
